// ===== hw/rtl/nwr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nwr_pkg: shared types and constants of the numeric word remover
// Character codes, classification functions, the drain sequencer state type
// and the command that starts a drain.
// ----------------------------------------------------------------------------
package nwr_pkg;

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

    typedef enum logic [1:0] {
        DR_IDLE,
        DR_READ,
        DR_WORD,
        DR_DELIM
    } drain_state_t;

    // Issued by the word tracker when a delimiter is transferred in.
    typedef struct packed {
        logic              start;
        logic              emit;
        logic              trunc;
        logic [CHAR_W-1:0] delim;
    } drain_cmd_t;

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return c inside {CH_SPACE, CH_PERIOD, CH_COMMA, CH_NEWLINE, CH_NUL};
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
    endfunction

endpackage : nwr_pkg
`default_nettype wire

// ===== hw/rtl/numeric_word_remover_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// numeric_word_remover_top: character filter that deletes numeric words
// Buffers each word, then on a delimiter drains the word (unless it holds a
// digit and no letter) followed by the delimiter itself.
// ----------------------------------------------------------------------------
// A non-delimiter byte produces no output and leaves the block ready for
// the next byte. A delimiter (space, period, comma, newline or the zero
// byte) starts a drain during which the block takes no input: with a word
// to emit, the drain first reads the word buffer, then sends the stored
// bytes one per cycle out of its single read port while m_ready is high,
// then the delimiter; otherwise only the delimiter goes out. Stalls on the
// result side lengthen the drain. Bytes beyond WORD_MAX in a word are
// dropped, and every transfer of that burst carries m_truncated. m_last
// marks the delimiter. The result is presented straight from the sequencer
// and the RAM's output register, and it holds while m_ready is low.
// ----------------------------------------------------------------------------
module numeric_word_remover_top
    import nwr_pkg::*;
#(
    parameter int WORD_MAX = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_ch,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_out_ch,
    output logic                   m_last,
    output logic                   m_truncated
);

    localparam int LEN_W  = $clog2(WORD_MAX + 1);
    localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    // Word tracking state: length so far and what kinds of characters
    // have been seen in the current word.
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic             saw_letter_reg, saw_letter_next;
    logic             saw_digit_reg, saw_digit_next;
    logic             overflowed_reg, overflowed_next;

    logic              s_xfer;
    logic              in_delim;
    logic              has_room;
    logic              emit;
    drain_cmd_t        cmd;
    logic              drain_idle;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    // Input is taken only while no drain is in progress.
    assign s_ready  = drain_idle;
    assign s_xfer   = s_valid && s_ready;
    assign in_delim = is_delim(s_ch);
    assign has_room = (word_len_reg < LEN_W'(WORD_MAX));

    // A word is emitted unless it is empty or purely numeric. Words made
    // only of symbols have neither flag set and therefore go out.
    assign emit = !(saw_digit_reg && !saw_letter_reg) && (word_len_reg != '0);

    assign cmd.start = s_xfer && in_delim;
    assign cmd.emit  = emit;
    assign cmd.trunc = emit && overflowed_reg;
    assign cmd.delim = s_ch;

    assign ram_we = s_xfer && !in_delim && has_room;

    always_comb begin
        word_len_next   = word_len_reg;
        saw_letter_next = saw_letter_reg;
        saw_digit_next  = saw_digit_reg;
        overflowed_next = overflowed_reg;
        if (s_xfer) begin
            if (in_delim) begin
                // The drain has latched what it needs; start a fresh word.
                word_len_next   = '0;
                saw_letter_next = 1'b0;
                saw_digit_next  = 1'b0;
                overflowed_next = 1'b0;
            end else begin
                // Dropped bytes still count toward the letter and digit flags.
                if (is_letter(s_ch)) begin
                    saw_letter_next = 1'b1;
                end
                if (is_digit(s_ch)) begin
                    saw_digit_next = 1'b1;
                end
                if (has_room) begin
                    word_len_next = word_len_reg + LEN_W'(1);
                end else begin
                    overflowed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg   <= '0;
            saw_letter_reg <= 1'b0;
            saw_digit_reg  <= 1'b0;
            overflowed_reg <= 1'b0;
        end else begin
            word_len_reg   <= word_len_next;
            saw_letter_reg <= saw_letter_next;
            saw_digit_reg  <= saw_digit_next;
            overflowed_reg <= overflowed_next;
        end
    end

    // Word buffer. Written while collecting, read only by the drain, and
    // the two never overlap because input is held off during a drain.
    nwr_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (WORD_MAX)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_len_reg[ADDR_W-1:0]),
        .wdata (s_ch),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nwr_drain #(
        .WORD_MAX (WORD_MAX)
    ) u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cmd_len     (word_len_reg),
        .idle        (drain_idle),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_ch    (m_out_ch),
        .m_last      (m_last),
        .m_truncated (m_truncated)
    );

`ifndef NO_ASSERTIONS
    // Input and output sides are never active together.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is presented");

    // A delimiter transfer starts a drain and clears the word tracker.
    a_delim_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && is_delim(s_ch)) |=>
            (!s_ready && word_len_reg == '0 && !overflowed_reg))
        else $error("delimiter did not start a drain or clear the word");

    // The stored length never exceeds the buffer depth.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        word_len_reg <= LEN_W'(WORD_MAX))
        else $error("word length beyond buffer depth");

    // Overflow is only ever flagged on a full buffer.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> (word_len_reg == LEN_W'(WORD_MAX)))
        else $error("overflow flagged with room left");
`endif

endmodule : numeric_word_remover_top
`default_nettype wire

// ===== hw/rtl/nwr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nwr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module nwr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                       wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                       rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : nwr_ram
`default_nettype wire

// ===== hw/rtl/nwr_drain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nwr_drain: word drain sequencer
// Reads the buffered word, if it is to be emitted, out of the RAM one byte
// per transfer and then presents the delimiter that ended it.
// ----------------------------------------------------------------------------
module nwr_drain
    import nwr_pkg::*;
#(
    parameter int WORD_MAX = 32
) (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire drain_cmd_t                                       cmd,
    input  wire logic [$clog2(WORD_MAX+1)-1:0]                    cmd_len,
    output logic                                                  idle,
    output logic                                                  ram_re,
    output logic [(WORD_MAX > 1 ? $clog2(WORD_MAX) : 1)-1:0]      ram_raddr,
    input  wire logic [CHAR_W-1:0]                                ram_rdata,
    output logic                                                  m_valid,
    input  wire logic                                             m_ready,
    output logic [CHAR_W-1:0]                                     m_out_ch,
    output logic                                                  m_last,
    output logic                                                  m_truncated
);

    localparam int LEN_W  = $clog2(WORD_MAX + 1);
    localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    drain_state_t      state_reg, state_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              trunc_reg, trunc_next;
    logic [CHAR_W-1:0] delim_reg, delim_next;
    logic [LEN_W-1:0]  idx_inc;
    logic              last_byte;

    assign idx_inc   = idx_reg + LEN_W'(1);
    assign last_byte = (idx_inc == cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        trunc_reg <= trunc_next;
        delim_reg <= delim_next;
    end

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        trunc_next = trunc_reg;
        delim_next = delim_reg;
        case (state_reg)
            DR_IDLE: begin
                if (cmd.start) begin
                    idx_next   = '0;
                    cnt_next   = cmd_len;
                    trunc_next = cmd.trunc;
                    delim_next = cmd.delim;
                    state_next = cmd.emit ? DR_READ : DR_DELIM;
                end
            end
            DR_READ: begin
                state_next = DR_WORD;
            end
            DR_WORD: begin
                if (m_ready) begin
                    idx_next   = idx_inc;
                    state_next = last_byte ? DR_DELIM : DR_WORD;
                end
            end
            DR_DELIM: begin
                if (m_ready) begin
                    state_next = DR_IDLE;
                end
            end
            default: begin
                state_next = DR_IDLE;
            end
        endcase
    end

    // Outputs. In the word state the next byte is fetched as soon as the
    // current one is taken, so bytes leave at one per cycle while m_ready is high.
    always_comb begin
        idle        = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg[ADDR_W-1:0];
        m_valid     = 1'b0;
        m_out_ch    = delim_reg;
        m_last      = 1'b0;
        m_truncated = trunc_reg;
        case (state_reg)
            DR_IDLE: begin
                idle = 1'b1;
            end
            DR_READ: begin
                ram_re = 1'b1;
            end
            DR_WORD: begin
                m_valid   = 1'b1;
                m_out_ch  = ram_rdata;
                ram_raddr = idx_inc[ADDR_W-1:0];
                ram_re    = m_ready && !last_byte;
            end
            DR_DELIM: begin
                m_valid = 1'b1;
                m_last  = 1'b1;
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

endmodule : nwr_drain
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the numeric word remover
// Feeds character streams through the input channel and checks every output
// transfer against a behavioral copy of the filter kept inside the bench.
// ----------------------------------------------------------------------------
// Stimulus is a handful of directed tests followed by three random phases
// that differ only in how often each side of the block idles. Each accepted
// input character is run through the bench's own filter, which queues the
// output transfers it implies. A checker process pops that queue on every
// output transfer and compares the three fields.
// ----------------------------------------------------------------------------
module tb_top;
    import nwr_pkg::*;

    localparam int WORD_MAX     = 32;
    // Random characters per idling phase; together with the directed tests
    // the run sends about 300.
    localparam int PHASE_ITEMS  = 80;
    // Cycles without any transfer before the run is declared hung. A full
    // drain moves at most WORD_MAX bytes and the delimiter, so this is generous.
    localparam int STALL_LIMIT  = 4000;
    // Quiet time after the last result, long enough for a full drain.
    localparam int QUIET_CYCLES = 2 * (WORD_MAX + 4);

    // One output transfer as the filter predicts it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              trunc;
    } beat_t;

    // Flavors of random words.
    typedef enum int {
        WK_ALPHA,
        WK_NUMERIC,
        WK_MIXED,
        WK_SYMBOL,
        WK_ANY
    } word_kind_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CHAR_W-1:0] s_ch;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_out_ch;
    logic              m_last;
    logic              m_truncated;

    numeric_word_remover_top #(
        .WORD_MAX(WORD_MAX)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_ch   (m_out_ch),
        .m_last     (m_last),
        .m_truncated(m_truncated)
    );

    // Idle rates in percent for the two sides, changed between phases.
    int send_idle_pct = 28;
    int recv_idle_pct = 67;

    // Bench copy of the word being collected.
    logic [CHAR_W-1:0] word_buf [WORD_MAX];
    int unsigned       word_cnt;
    bit                has_alpha;
    bit                has_num;
    bit                word_cut;

    // Output transfers still owed by the block, oldest first.
    beat_t beat_q [$];

    int err_cnt       = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int kept_words    = 0;
    int numeric_words = 0;
    int cut_words     = 0;
    int stall_cnt     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Character classes, written out here rather than borrowed from the
    // package so the prediction stays independent of the design.
    // ------------------------------------------------------------------------
    function automatic bit char_is_sep(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_PERIOD || c == CH_COMMA ||
               c == CH_NEWLINE || c == CH_NUL;
    endfunction

    function automatic bit char_is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit char_is_num(input logic [CHAR_W-1:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    // ------------------------------------------------------------------------
    // The filter itself. A non-delimiter is buffered (or dropped past
    // WORD_MAX, which marks the word as cut). A delimiter releases the word
    // unless it had a digit and no letter, then the delimiter goes out with
    // last set. The truncation flag only rides on bursts that carry the word.
    // ------------------------------------------------------------------------
    function automatic void filter_char(input logic [CHAR_W-1:0] c);
        bit keep;
        bit cut;
        if (!char_is_sep(c)) begin
            if (char_is_alpha(c)) begin
                has_alpha = 1'b1;
            end else if (char_is_num(c)) begin
                has_num = 1'b1;
            end
            if (word_cnt < WORD_MAX) begin
                word_buf[word_cnt] = c;
                word_cnt++;
            end else begin
                word_cut = 1'b1;
            end
        end else begin
            keep = !(has_num && !has_alpha) && word_cnt > 0;
            cut  = keep && word_cut;
            if (keep) begin
                for (int k = 0; k < word_cnt; k++) begin
                    beat_q.push_back('{ch: word_buf[k], last: 1'b0, trunc: cut});
                end
                kept_words++;
                if (cut) begin
                    cut_words++;
                end
            end else if (word_cnt > 0) begin
                numeric_words++;
            end
            beat_q.push_back('{ch: c, last: 1'b1, trunc: cut});
            // A delimiter always starts a fresh word.
            word_cnt  = 0;
            has_alpha = 1'b0;
            has_num   = 1'b0;
            word_cut  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: ready is redrawn every falling edge from the current
    // idle rate. With a rate of zero it simply stays high.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker: every output transfer must match the oldest prediction.
    // Outputs are sampled at the rising edge, where the transfer happens.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beat_q.size() == 0) begin
                $error("unexpected result transfer: out_ch=%02h last=%0b truncated=%0b",
                       m_out_ch, m_last, m_truncated);
                err_cnt++;
            end else begin
                want = beat_q.pop_front();
                beats_checked++;
                if (m_out_ch !== want.ch) begin
                    $error("out_ch mismatch: expected %02h, actual %02h", want.ch, m_out_ch);
                    err_cnt++;
                end
                if (m_last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, m_last);
                    err_cnt++;
                end
                if (m_truncated !== want.trunc) begin
                    $error("truncated mismatch: expected %0b, actual %0b",
                           want.trunc, m_truncated);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel completes a transfer.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog expired after %0d cycles without a transfer", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sends one character. Entered and left at a falling edge. Random idle
    // cycles come first, with garbage on the data lines while valid is low.
    // Valid is left high on exit so back-to-back transfers need no toggle;
    // the next call or the end of the run decides whether it drops.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_ch    <= CHAR_W'($urandom);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        filter_char(c);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_alpha();
        if ($urandom_range(0, 1) == 0) begin
            return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
        end
        return CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CH_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
    endfunction

    // Any byte that is neither a delimiter, a letter nor a digit.
    function automatic logic [CHAR_W-1:0] rand_symbol();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom);
        end while (char_is_sep(c) || char_is_alpha(c) || char_is_num(c));
        return c;
    endfunction

    // Any byte that is not a delimiter.
    function automatic logic [CHAR_W-1:0] rand_word_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom);
        end while (char_is_sep(c));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_sep();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_PERIOD;
            2:       return CH_COMMA;
            3:       return CH_NEWLINE;
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input word_kind_t kind);
        case (kind)
            WK_ALPHA:   return rand_alpha();
            WK_NUMERIC: return rand_digit();
            WK_SYMBOL:  return rand_symbol();
            WK_MIXED: begin
                case ($urandom_range(0, 2))
                    0:       return rand_alpha();
                    1:       return rand_digit();
                    default: return rand_symbol();
                endcase
            end
            default:    return rand_word_char();
        endcase
    endfunction

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Letters at both ends of both ranges: the word is passed through.
    task automatic test_letter_words();
        send_text("AZaz");
        send_char(CH_SPACE);
    endtask

    // A digits-only word is deleted, while a digit next to a letter keeps it.
    // A digit with a non-letter symbol is still numeric and is deleted.
    task automatic test_numeric_words();
        send_text("09");
        send_char(CH_PERIOD);
        send_text("0a");
        send_char(CH_COMMA);
        send_char(CH_DIGIT_9);
        send_char(8'hFF);
        send_char(CH_NUL);
    endtask

    // Bytes just outside the letter and digit ranges, plus the byte extremes,
    // form a word with no letter and no digit, which must be passed through.
    task automatic test_symbol_words();
        send_char(8'h40);
        send_char(8'h5B);
        send_char(8'h60);
        send_char(8'h7B);
        send_char(8'h2F);
        send_char(8'h3A);
        send_char(8'h01);
        send_char(8'hFF);
        send_char(CH_NEWLINE);
    endtask

    // Delimiter right after a delimiter: only the delimiter comes out.
    task automatic test_empty_words();
        send_char(CH_NUL);
        send_char(CH_SPACE);
    endtask

    // One byte past the buffer: the extra byte is dropped and the whole
    // burst carries the truncation flag.
    task automatic test_long_word();
        for (int i = 0; i <= WORD_MAX; i++) begin
            send_char(rand_alpha());
        end
        send_char(CH_COMMA);
    endtask

    // ------------------------------------------------------------------------
    // Random stream: mostly well-formed words of random flavor and length,
    // ended by a random delimiter, with some loose random bytes mixed in.
    // Lengths are mostly short; a few straddle WORD_MAX to hit overflow.
    // ------------------------------------------------------------------------
    task automatic test_random_stream(input int n_items);
        int         first;
        int         len;
        int         roll;
        word_kind_t kind;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(0, 99) < 10) begin
                send_char(CHAR_W'($urandom));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    len = $urandom_range(WORD_MAX - 4, WORD_MAX + 8);
                end else if (roll < 18) begin
                    len = 0;
                end else begin
                    len = $urandom_range(1, 8);
                end
                kind = word_kind_t'($urandom_range(WK_ALPHA, WK_ANY));
                for (int i = 0; i < len; i++) begin
                    send_char(pick_char(kind));
                end
                send_char(rand_sep());
            end
        end
        // Flush whatever word the loose bytes may have left open.
        send_char(CH_NEWLINE);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_ch      = '0;
        m_ready   = 1'b0;
        word_cnt  = 0;
        has_alpha = 1'b0;
        has_num   = 1'b0;
        word_cut  = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles now and then, receiver idles a lot.
        send_idle_pct = 28;
        recv_idle_pct = 67;
        test_letter_words();
        test_numeric_words();
        test_symbol_words();
        test_empty_words();
        test_long_word();
        test_random_stream(PHASE_ITEMS);

        // Phase two: the roles are swapped.
        send_idle_pct = 67;
        recv_idle_pct = 28;
        test_random_stream(PHASE_ITEMS);

        // Phase three: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(PHASE_ITEMS);

        s_valid <= 1'b0;

        // Wait for every predicted transfer, then stay a while to catch any
        // stray output. The watchdog covers a block that never finishes.
        while (beat_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (QUIET_CYCLES) @(posedge aclk);

        $display("sent %0d characters, checked %0d output transfers", items_sent,
                 beats_checked);
        $display("words kept %0d, numeric words removed %0d, truncated words %0d",
                 kept_words, numeric_words, cut_words);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire

// ===== files.f =====
hw/rtl/nwr_pkg.sv
hw/rtl/nwr_ram.sv
hw/rtl/nwr_drain.sv
hw/rtl/numeric_word_remover_top.sv
tb/tb_top.sv
